// ===== rtl/e2cd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2cd_pkg
// Shared types, constants and the control store of the epoch to civil date
// converter.
// ----------------------------------------------------------------------------
package e2cd_pkg;

	// Microsecond divide: drop six low bits (a divide by 64), then divide by 15625
	localparam int unsigned USEC_SHIFT = 6;

	// Divisors of the shared reciprocal divider
	localparam logic [13:0] USEC_ODD     = 14'd15625;
	localparam logic [13:0] SEC_PER_MIN  = 14'd60;
	localparam logic [13:0] HOUR_PER_DAY = 14'd24;

	// Reciprocals, rounded up: quotient is (x * reciprocal) >> shift.
	// The first is exact for x below 2^30, the other two for any 32-bit x.
	localparam logic [31:0] RCP_ODD   = 32'd1125899907;
	localparam logic [31:0] RCP_SIXTY = 32'h8888_8889;
	localparam logic [31:0] RCP_DAY   = 32'hAAAA_AAAB;

	// Calendar constants
	localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
	localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
	localparam logic [6:0]  LAST_MOD100  = 7'd99;
	localparam logic [8:0]  LAST_MOD400  = 9'd399;
	localparam logic [8:0]  YEAR_DAYS    = 9'd365;
	localparam logic [3:0]  MONTH_JAN    = 4'd0;
	localparam logic [3:0]  MONTH_FEB    = 4'd1;
	localparam logic [3:0]  MONTH_DEC    = 4'd11;

	// Passes of the microsecond digit loop, less one: four 16-bit digits
	localparam logic [1:0] CNT_DIGITS = 2'd3;

	// Micro-operations
	localparam logic [3:0] OP_WAIT  = 4'd0;
	localparam logic [3:0] OP_DIV   = 4'd1;
	localparam logic [3:0] OP_DIGIT = 4'd2;
	localparam logic [3:0] OP_SUM   = 4'd3;
	localparam logic [3:0] OP_SEC   = 4'd4;
	localparam logic [3:0] OP_MIN   = 4'd5;
	localparam logic [3:0] OP_HOUR  = 4'd6;
	localparam logic [3:0] OP_YEAR  = 4'd7;
	localparam logic [3:0] OP_MONTH = 4'd8;
	localparam logic [3:0] OP_OUT   = 4'd9;

	// Divisor selects
	localparam logic [1:0] DSEL_MEG   = 2'd0;
	localparam logic [1:0] DSEL_SIXTY = 2'd1;
	localparam logic [1:0] DSEL_DAY   = 2'd2;

	// Program addresses
	localparam logic [3:0] PC_WAIT = 4'd0;
	localparam logic [3:0] PC_USEC = 4'd1;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] dsel;
		logic       jmp;
		logic       jnz;
		logic [3:0] target;
	} ctl_t;

	// Control store: one word per step
	function automatic ctl_t ucode(input logic [3:0] pc);
		ctl_t cw;
		cw = '{op: OP_WAIT, dsel: DSEL_MEG, jmp: 1'b0, jnz: 1'b0, target: PC_WAIT};
		case (pc)
			4'd0:  cw = '{op: OP_WAIT,  dsel: DSEL_MEG,   jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd1:  cw = '{op: OP_DIV,   dsel: DSEL_MEG,   jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd2:  cw = '{op: OP_DIGIT, dsel: DSEL_MEG,   jmp: 1'b0, jnz: 1'b1,
				target: PC_USEC};
			4'd3:  cw = '{op: OP_SUM,   dsel: DSEL_SIXTY, jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd4:  cw = '{op: OP_DIV,   dsel: DSEL_SIXTY, jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd5:  cw = '{op: OP_SEC,   dsel: DSEL_SIXTY, jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd6:  cw = '{op: OP_DIV,   dsel: DSEL_SIXTY, jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd7:  cw = '{op: OP_MIN,   dsel: DSEL_SIXTY, jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd8:  cw = '{op: OP_DIV,   dsel: DSEL_DAY,   jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd9:  cw = '{op: OP_HOUR,  dsel: DSEL_DAY,   jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd10: cw = '{op: OP_YEAR,  dsel: DSEL_MEG,   jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd11: cw = '{op: OP_MONTH, dsel: DSEL_MEG,   jmp: 1'b0, jnz: 1'b0,
				target: PC_WAIT};
			4'd12: cw = '{op: OP_OUT,   dsel: DSEL_MEG,   jmp: 1'b1, jnz: 1'b0,
				target: PC_WAIT};
			default: cw = '{op: OP_OUT, dsel: DSEL_MEG,   jmp: 1'b1, jnz: 1'b0,
				target: PC_WAIT};
		endcase
		return cw;
	endfunction

	function automatic logic [13:0] divisor(input logic [1:0] dsel);
		logic [13:0] d;
		case (dsel)
			DSEL_MEG:   d = USEC_ODD;
			DSEL_SIXTY: d = SEC_PER_MIN;
			DSEL_DAY:   d = HOUR_PER_DAY;
			default:    d = USEC_ODD;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] reciprocal(input logic [1:0] dsel);
		logic [31:0] r;
		case (dsel)
			DSEL_MEG:   r = RCP_ODD;
			DSEL_SIXTY: r = RCP_SIXTY;
			DSEL_DAY:   r = RCP_DAY;
			default:    r = RCP_ODD;
		endcase
		return r;
	endfunction

	// Days per month in a common year, January first
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd0:    len = 5'd31;
			4'd1:    len = 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/e2cd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2cd interfaces
// Valid/ready channels for the timestamp beat and the civil date beat.
// ----------------------------------------------------------------------------
interface e2cd_stamp_if;
	logic               valid;
	logic               ready;
	logic        [31:0] base_seconds;
	logic signed [63:0] offset_micros;

	modport source (output valid, output base_seconds, output offset_micros, input ready);
	modport sink   (input valid, input base_seconds, input offset_micros, output ready);
endinterface

interface e2cd_date_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	modport source (output valid, output year, output month, output day, output hour,
		output minute, output second, input ready);
	modport sink   (input valid, input year, input month, input day, input hour,
		input minute, input second, output ready);
endinterface
`default_nettype wire

// ===== rtl/epoch_to_civil_date_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_civil_date_top
// Unix epoch seconds plus a signed microsecond offset to a UTC calendar date.
// ----------------------------------------------------------------------------
// One timestamp beat is taken at a time and turned into one date beat. A
// sequencer running a thirteen-word control store drives one reciprocal
// divider: a 32 by 32 multiply gives a quotient in a divide step and the
// remainder follows in the step after it. The microsecond offset is shifted
// down six bits (a divide by 64) and then divided by 15625 as four 16-bit
// digits; then the sum with the base is formed and the divides by 60, 60
// and 24 each take a divide step and a remainder step. The year is then
// stepped one per cycle from 1970 and the month one per cycle. The date
// beat waits in an output register, so the next timestamp is accepted
// while it is still held; only the final write into that register waits
// for it to be taken.
// ----------------------------------------------------------------------------
module epoch_to_civil_date_top (
	input  logic               clk,
	input  logic               arst_n,
	e2cd_stamp_if.sink         stamp,
	e2cd_date_if.source        date
);

	// Control
	logic [3:0]        pc_q;
	logic [1:0]        cnt_q;
	e2cd_pkg::ctl_t    cw;
	logic              hold;
	logic              take_jump;

	// Datapath
	logic [63:0]       num_q;
	logic [13:0]       rem_q;
	logic [31:0]       quo_q;
	logic [31:0]       qt_q;
	logic [31:0]       tv_q;
	logic              neg_q;
	logic [31:0]       base_q;
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hour_q;
	logic [15:0]       days_q;
	logic [11:0]       year_q;
	logic [6:0]        c100_q;
	logic [8:0]        c400_q;
	logic [3:0]        month_q;

	// Output register
	logic              out_valid_q;
	logic [11:0]       year_out_q;
	logic [3:0]        month_out_q;
	logic [4:0]        day_out_q;
	logic [4:0]        hour_out_q;
	logic [5:0]        min_out_q;
	logic [5:0]        sec_out_q;

	logic [63:0]       off_raw;
	logic [63:0]       mag;
	logic [31:0]       dvd;
	logic [31:0]       rcp;
	logic [63:0]       prod;
	logic [31:0]       qt_nx;
	logic [13:0]       dvsr;
	logic [31:0]       qd;
	logic [31:0]       rem_full;
	logic [31:0]       q_sgn;
	logic [31:0]       tsum;
	logic              leap;
	logic [8:0]        ylen;
	logic              year_go;
	logic [4:0]        mlen;
	logic              month_go;
	logic              slot_free;

	// Decode the current control word
	assign cw        = e2cd_pkg::ucode(pc_q);
	assign take_jump = cw.jmp || (cw.jnz && (cnt_q != 2'd0));

	// Magnitude of the offset
	assign off_raw = stamp.offset_micros;
	assign mag     = off_raw[63] ? (~off_raw + 64'd1) : off_raw;

	// Dividend: next microsecond digit under the running remainder, else the time
	assign dvd = (cw.dsel == e2cd_pkg::DSEL_MEG) ? {2'd0, rem_q, num_q[63:48]} : tv_q;

	// Quotient by reciprocal multiplication
	assign rcp  = e2cd_pkg::reciprocal(cw.dsel);
	assign prod = {32'd0, dvd} * {32'd0, rcp};

	always_comb begin
		case (cw.dsel)
			e2cd_pkg::DSEL_MEG:   qt_nx = {12'd0, prod[63:44]};
			e2cd_pkg::DSEL_SIXTY: qt_nx = {5'd0, prod[63:37]};
			e2cd_pkg::DSEL_DAY:   qt_nx = {4'd0, prod[63:36]};
			default:              qt_nx = {12'd0, prod[63:44]};
		endcase
	end

	// Remainder from the registered quotient
	assign dvsr     = e2cd_pkg::divisor(cw.dsel);
	assign qd       = qt_q * {18'd0, dvsr};
	assign rem_full = dvd - qd;

	// Apply the sign to the second count and add the base, modulo 2^32
	assign q_sgn = neg_q ? (~quo_q + 32'd1) : quo_q;
	assign tsum  = base_q + q_sgn;

	// Leap rule from the running year residues
	assign leap    = (year_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
	assign ylen    = e2cd_pkg::YEAR_DAYS + {8'd0, leap};
	assign year_go = (days_q >= {7'd0, ylen});

	// Month length with the February correction
	assign mlen     = e2cd_pkg::month_len(month_q) +
		{4'd0, (month_q == e2cd_pkg::MONTH_FEB) && leap};
	assign month_go = (month_q < e2cd_pkg::MONTH_DEC) && (days_q >= {11'd0, mlen});

	assign slot_free = !out_valid_q || date.ready;

	// Hold the step while its loop or handshake is not done
	always_comb begin
		case (cw.op)
			e2cd_pkg::OP_WAIT:  hold = !stamp.valid;
			e2cd_pkg::OP_YEAR:  hold = year_go;
			e2cd_pkg::OP_MONTH: hold = month_go;
			e2cd_pkg::OP_OUT:   hold = !slot_free;
			default:            hold = 1'b0;
		endcase
	end

	// Step counter, digit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= e2cd_pkg::PC_WAIT;
			cnt_q       <= e2cd_pkg::CNT_DIGITS;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold) begin
				pc_q <= take_jump ? cw.target : (pc_q + 4'd1);
			end
			if (cw.op == e2cd_pkg::OP_WAIT) begin
				cnt_q <= e2cd_pkg::CNT_DIGITS;
			end else if ((cw.op == e2cd_pkg::OP_DIGIT) && (cnt_q != 2'd0)) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if ((cw.op == e2cd_pkg::OP_OUT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (date.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, driven by the micro-operation
	always_ff @(posedge clk) begin
		case (cw.op)
			e2cd_pkg::OP_WAIT: begin
				if (stamp.valid) begin
					num_q  <= mag >> e2cd_pkg::USEC_SHIFT;
					rem_q  <= 14'd0;
					neg_q  <= off_raw[63];
					base_q <= stamp.base_seconds;
				end
			end
			e2cd_pkg::OP_DIV: begin
				qt_q <= qt_nx;
			end
			e2cd_pkg::OP_DIGIT: begin
				rem_q <= rem_full[13:0];
				quo_q <= {quo_q[15:0], qt_q[15:0]};
				num_q <= {num_q[47:0], 16'd0};
			end
			e2cd_pkg::OP_SUM: begin
				tv_q <= tsum;
			end
			e2cd_pkg::OP_SEC: begin
				sec_q <= rem_full[5:0];
				tv_q  <= qt_q;
			end
			e2cd_pkg::OP_MIN: begin
				min_q <= rem_full[5:0];
				tv_q  <= qt_q;
			end
			e2cd_pkg::OP_HOUR: begin
				hour_q  <= rem_full[4:0];
				days_q  <= qt_q[15:0];
				year_q  <= e2cd_pkg::EPOCH_YEAR;
				c100_q  <= e2cd_pkg::EPOCH_MOD100;
				c400_q  <= e2cd_pkg::EPOCH_MOD400;
				month_q <= e2cd_pkg::MONTH_JAN;
			end
			e2cd_pkg::OP_YEAR: begin
				if (year_go) begin
					days_q <= days_q - {7'd0, ylen};
					year_q <= year_q + 12'd1;
					c100_q <= (c100_q == e2cd_pkg::LAST_MOD100) ? 7'd0 : (c100_q + 7'd1);
					c400_q <= (c400_q == e2cd_pkg::LAST_MOD400) ? 9'd0 : (c400_q + 9'd1);
				end
			end
			e2cd_pkg::OP_MONTH: begin
				if (month_go) begin
					days_q  <= days_q - {11'd0, mlen};
					month_q <= month_q + 4'd1;
				end
			end
			e2cd_pkg::OP_OUT: begin
				if (slot_free) begin
					year_out_q  <= year_q;
					month_out_q <= month_q + 4'd1;
					day_out_q   <= days_q[4:0] + 5'd1;
					hour_out_q  <= hour_q;
					min_out_q   <= min_q;
					sec_out_q   <= sec_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Ports
	assign stamp.ready = (cw.op == e2cd_pkg::OP_WAIT);
	assign date.valid  = out_valid_q;
	assign date.year   = year_out_q;
	assign date.month  = month_out_q;
	assign date.day    = day_out_q;
	assign date.hour   = hour_out_q;
	assign date.minute = min_out_q;
	assign date.second = sec_out_q;

	// Checks
	a_load_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp.valid && stamp.ready) |=> (cnt_q == e2cd_pkg::CNT_DIGITS) &&
		(cw.op == e2cd_pkg::OP_DIV) && (pc_q == e2cd_pkg::PC_USEC))
		else $error("divider not primed for the microsecond divide");

	a_digit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == e2cd_pkg::OP_DIGIT) |-> (rem_full < {18'd0, e2cd_pkg::USEC_ODD}))
		else $error("microsecond digit remainder out of range");

	a_rose_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(date.valid) |-> ($past(cw.op) == e2cd_pkg::OP_OUT))
		else $error("date beat raised outside the output step");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid |-> (date.month >= 4'd1) && (date.month <= 4'd12) &&
		(date.day >= 5'd1) && (date.hour <= 5'd23) && (date.minute <= 6'd59) &&
		(date.second <= 6'd59))
		else $error("date beat field out of range");

	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == e2cd_pkg::OP_MONTH) |-> (year_q <= 12'd2106) && (days_q < 16'd366))
		else $error("year stepping overran");

endmodule
`default_nettype wire
